### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/kst_pkg.sv
// Shared types and constants of the smoothed tilt sensor.
package kst_pkg;
    localparam int SAMPLE_W = 16;
    localparam int EST_W    = 24;
    localparam int COV_W    = 20;
    localparam int ANG_W    = 16;
    localparam int THR_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int ATAN_N   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_THRESHOLD    = 2'd2;

    localparam logic [1:0] CLASS_LEVEL = 2'd0;
    localparam logic [1:0] CLASS_POS   = 2'd1;
    localparam logic [1:0] CLASS_NEG   = 2'd2;

    localparam logic signed [15:0] ANG_LIMIT = 16'sd23040;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
    } sample_t;

    typedef struct packed {
        logic signed [EST_W-1:0] sx;
        logic signed [EST_W-1:0] sy;
        logic signed [EST_W-1:0] sz;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] yaw;
        logic [1:0]              pcls;
        logic [1:0]              rcls;
    } result_t;

    function automatic logic [21:0] atan_lut(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage

### rtl/kst_front.sv
// Input side: takes samples, sign-extends them and queues them for the core.
module kst_front
    import kst_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t in_data,
    output logic    q_valid,
    input  logic    q_ready,
    output sample_t q_data
);
    sample_t    mem_reg [2];
    logic [1:0] wp_reg, rp_reg;
    logic [1:0] wp_next, rp_next;
    sample_t    ext;

    function automatic logic signed [SAMPLE_W-1:0] sx(input logic [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        r = SAMPLE_W'(signed'(v[SAMPLE_BITS-1:0]));
        return r;
    endfunction

    always_comb begin
        ext.ax = sx(in_data.ax);
        ext.ay = sx(in_data.ay);
        ext.az = sx(in_data.az);
    end

    assign in_ready = (wp_reg - rp_reg) != 2'd2;
    assign q_valid  = wp_reg != rp_reg;
    assign q_data   = mem_reg[rp_reg[0]];
    assign wp_next  = wp_reg + 2'(in_valid && in_ready);
    assign rp_next  = rp_reg + 2'(q_valid && q_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
        if (in_valid && in_ready) begin
            mem_reg[wp_reg[0]] <= ext;
        end
    end
endmodule

### rtl/kst_core.sv
// Back end: per-axis Kalman update, square root, CORDIC angles and output register.
module kst_core
    import kst_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  sample_t          q_data,
    input  logic [COV_W-1:0] proc_noise,
    input  logic [COV_W-1:0] meas_noise,
    input  logic [THR_W-1:0] threshold,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_data
);
    localparam int IT_W = $clog2(ATAN_N + 1);
    localparam int ITERS = (ANGLE_ITERATIONS < ATAN_N) ? ANGLE_ITERATIONS : ATAN_N;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PADD  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_UPD   = 10'b0000010000,
        S_SQ    = 10'b0000100000,
        S_SQRT  = 10'b0001000000,
        S_NORM  = 10'b0010000000,
        S_ROT   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [EST_W-1:0] est_reg [3];
    logic [COV_W-1:0]        cov_reg [3];
    sample_t                 smp_reg;
    logic [1:0]              ax_reg;
    logic [COV_W-1:0]        p1_reg;
    logic [21:0]             den_reg;
    logic [36:0]             rem_reg;
    logic [16:0]             k_reg;
    logic [5:0]              cnt_reg;
    logic signed [42:0]      prod_reg;
    logic [37:0]             pprod_reg;
    logic [48:0]             sqv_reg;
    logic [24:0]             root_reg;
    logic signed [33:0]      cx_reg, cy_reg;
    logic signed [23:0]      cz_reg;
    logic [IT_W-1:0]         it_reg;
    logic                    zero_reg;
    logic signed [ANG_W-1:0] ang_reg [3];
    logic                    ov_reg;
    result_t                 od_reg;

    logic signed [EST_W-1:0] cur_est, a_est, b_est, c_est;
    logic signed [SAMPLE_W-1:0] cur_smp;
    logic [20:0] psum;
    logic [37:0] rtry;
    logic signed [25:0] diff;
    logic signed [26:0] xnew;
    logic signed [42:0] rnd;
    logic signed [47:0] bsq, csq;
    logic [49:0] rb;
    logic signed [33:0] dx, dy;
    logic signed [23:0] zr;
    logic signed [16:0] angr;
    logic signed [ANG_W-1:0] angc;
    logic [ANG_W-1:0] tsx;

    always_comb begin
        cur_est = est_reg[ax_reg];
        case (ax_reg)
            2'd0:    cur_smp = smp_reg.ax;
            2'd1:    cur_smp = smp_reg.ay;
            default: cur_smp = smp_reg.az;
        endcase
        case (ax_reg)
            2'd0:    begin a_est = est_reg[0]; b_est = est_reg[1]; c_est = est_reg[2]; end
            2'd1:    begin a_est = est_reg[1]; b_est = est_reg[0]; c_est = est_reg[2]; end
            default: begin a_est = est_reg[2]; b_est = est_reg[0]; c_est = est_reg[1]; end
        endcase
        psum = 21'(cov_reg[ax_reg]) + 21'(proc_noise);
        rtry = {rem_reg, 1'b0};
        diff = 26'(signed'({cur_smp, 8'd0})) - 26'(cur_est);
        rnd = prod_reg[42] ? -((-prod_reg + 43'sd32768) >>> 16)
                           : ((prod_reg + 43'sd32768) >>> 16);
        xnew = 27'(cur_est) + 27'(rnd);
        bsq = b_est * b_est;
        csq = c_est * c_est;
        rb = {root_reg, 2'b00} | 50'd1;
        dx = cy_reg >>> it_reg;
        dy = cx_reg >>> it_reg;
        zr = cz_reg[23] ? -((-cz_reg + 24'sd128) >>> 8) : ((cz_reg + 24'sd128) >>> 8);
        angr = zero_reg ? 17'sd0 : 17'(zr);
        if (angr > 17'(ANG_LIMIT))       angc = ANG_LIMIT;
        else if (angr < -17'(ANG_LIMIT)) angc = -ANG_LIMIT;
        else                             angc = ANG_W'(angr);
        tsx = ANG_W'(threshold);
    end

    function automatic logic [1:0] cls(input logic signed [ANG_W-1:0] a,
                                       input logic [ANG_W-1:0] t);
        logic [1:0] c;
        if (a > signed'(t))       c = CLASS_POS;
        else if (a < -signed'(t)) c = CLASS_NEG;
        else                      c = CLASS_LEVEL;
        return c;
    endfunction

    assign q_ready   = state_reg == S_IDLE;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_PADD;
            S_PADD: state_next = S_DIV;
            S_DIV:  if (cnt_reg == 6'd16) state_next = S_MUL;
            S_MUL:  state_next = S_UPD;
            S_UPD:  state_next = (ax_reg == 2'd2) ? S_SQ : S_PADD;
            S_SQ:   state_next = S_SQRT;
            S_SQRT: if (cnt_reg == 6'd24) state_next = S_NORM;
            S_NORM: if (cx_reg[33:30] != 4'h0 && cx_reg[33:30] != 4'hF
                        || cy_reg[33:30] != 4'h0 && cy_reg[33:30] != 4'hF
                        || cx_reg == -34'sh40000000 || cy_reg == -34'sh40000000
                        || zero_reg)
                        state_next = S_ROT;
            S_ROT:  if (it_reg == IT_W'(ITERS)) state_next = (ax_reg == 2'd2) ? S_DONE : S_SQ;
            S_DONE: if (!ov_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                est_reg[i] <= '0;
                cov_reg[i] <= COV_W'(65536);
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!ov_reg || out_ready)) begin
                ov_reg <= 1'b1;
            end else if (ov_reg && out_ready) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    smp_reg <= q_data;
                    ax_reg  <= '0;
                end
                S_PADD: begin
                    p1_reg  <= psum[20] ? {COV_W{1'b1}} : psum[COV_W-1:0];
                    den_reg <= 22'(psum[20] ? {COV_W{1'b1}} : psum[COV_W-1:0])
                               + 22'(meas_noise);
                    rem_reg <= 37'(psum[20] ? {COV_W{1'b1}} : psum[COV_W-1:0]);
                    k_reg   <= '0;
                    cnt_reg <= '0;
                end
                S_DIV: begin
                    if (den_reg == '0) begin
                        k_reg <= '0;
                        cnt_reg <= 6'd16;
                    end else begin
                        if (cnt_reg == 6'd0) begin
                            if (rem_reg >= 37'(den_reg)) begin
                                rem_reg <= rem_reg - 37'(den_reg);
                                k_reg <= 17'd1;
                            end
                        end else begin
                            if (rtry >= 38'(den_reg)) begin
                                rem_reg <= 37'(rtry - 38'(den_reg));
                                k_reg <= {k_reg[15:0], 1'b1};
                            end else begin
                                rem_reg <= rtry[36:0];
                                k_reg <= {k_reg[15:0], 1'b0};
                            end
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_MUL: begin
                    prod_reg  <= signed'({1'b0, k_reg}) * 43'(diff);
                    pprod_reg <= 38'(p1_reg) * 38'(17'd65536 - k_reg);
                end
                S_UPD: begin
                    if (xnew > 27'sd8388607)       est_reg[ax_reg] <= 24'sh7FFFFF;
                    else if (xnew < -27'sd8388608) est_reg[ax_reg] <= -24'sd8388608;
                    else                           est_reg[ax_reg] <= EST_W'(xnew);
                    cov_reg[ax_reg] <= COV_W'((pprod_reg + 38'd32768) >> 16);
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                S_SQ: begin
                    sqv_reg  <= 49'(unsigned'(bsq)) + 49'(unsigned'(csq));
                    root_reg <= '0;
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                end
                S_SQRT: begin
                    if (cnt_reg == 6'd24) begin
                        cx_reg <= 34'(root_reg);
                        cy_reg <= 34'(a_est);
                        cz_reg <= '0;
                        it_reg <= '0;
                        zero_reg <= (a_est == '0) && (root_reg == '0);
                    end else begin
                        if ({rem_reg[24:0], sqv_reg[47:46]} >= rb[26:0]) begin
                            rem_reg  <= 37'({rem_reg[24:0], sqv_reg[47:46]} - rb[26:0]);
                            root_reg <= {root_reg[23:0], 1'b1};
                        end else begin
                            rem_reg  <= 37'({rem_reg[24:0], sqv_reg[47:46]});
                            root_reg <= {root_reg[23:0], 1'b0};
                        end
                        sqv_reg <= {sqv_reg[46:0], 2'b00};
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_NORM: begin
                    if (state_next == S_NORM) begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                end
                S_ROT: begin
                    if (it_reg == IT_W'(ITERS)) begin
                        ang_reg[ax_reg] <= angc;
                        ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                    end else begin
                        if (!cy_reg[33]) begin
                            cx_reg <= cx_reg + dx;
                            cy_reg <= cy_reg - dy;
                            cz_reg <= cz_reg + 24'(atan_lut(5'(it_reg)));
                        end else begin
                            cx_reg <= cx_reg - dx;
                            cy_reg <= cy_reg + dy;
                            cz_reg <= cz_reg - 24'(atan_lut(5'(it_reg)));
                        end
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!ov_reg || out_ready) begin
                        od_reg.sx    <= est_reg[0];
                        od_reg.sy    <= est_reg[1];
                        od_reg.sz    <= est_reg[2];
                        od_reg.pitch <= ang_reg[0];
                        od_reg.roll  <= ang_reg[1];
                        od_reg.yaw   <= ang_reg[2];
                        od_reg.pcls  <= cls(ang_reg[0], tsx);
                        od_reg.rcls  <= cls(ang_reg[1], tsx);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/kalman_smoothed_tilt_sensor_core.sv
// Top level of the smoothed tilt sensor: configuration, input queue and core.
// Usage:
//   s_axis: one accelerometer sample per item (x, y, z signed 16 bit).
//   m_axis: one result item per sample: three Q16.8 estimates, pitch, roll
//   and yaw in Q8.8 degrees, and two 2-bit tilt classes in tuser.
//   cfg: index 0 process noise, 1 measurement noise, 2 tilt threshold;
//   other indexes are dropped. Write only while the block is idle.
// Steps per item: pick up the sample; per axis the Kalman update with a
//   bit-serial gain divider; per angle the square root, the normalizing
//   shifts and the CORDIC rotation; then load the output register.
//   One item is worked on at a time; a two-entry queue in front accepts
//   the next samples meanwhile.
// Reset: estimates clear to zero, covariances to 1.0, registers to
//   their defaults, the queue and output empty.
// Stall: a held result stays in the output register; the core finishes
//   the next item and waits for the register to free.
module kalman_smoothed_tilt_sensor_core
    import kst_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // accel_x, accel_y, accel_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // smooth_x,y,z, pitch_deg, roll_deg, yaw_deg, 0 pad
    output logic [3:0]   m_tuser,   // pitch_class, roll_class
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data
);
    logic [COV_W-1:0] q_reg, r_reg;
    logic [THR_W-1:0] thr_reg;
    sample_t in_s, qd;
    logic    qv, qr;
    result_t res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg   <= COV_W'(6554);
            r_reg   <= COV_W'(6554);
            thr_reg <= THR_W'(1280);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROCESS_NOISE:     q_reg   <= cfg_data;
                REG_MEASUREMENT_NOISE: r_reg   <= cfg_data;
                REG_TILT_THRESHOLD:    thr_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_s.ax = s_tdata[15:0];
    assign in_s.ay = s_tdata[31:16];
    assign in_s.az = s_tdata[47:32];

    kst_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(in_s),
        .q_valid(qv), .q_ready(qr), .q_data(qd)
    );

    kst_core #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_core (
        .aclk, .aresetn,
        .q_valid(qv), .q_ready(qr), .q_data(qd),
        .proc_noise(q_reg), .meas_noise(r_reg), .threshold(thr_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    assign m_tdata = {8'd0, res.yaw, res.roll, res.pitch, res.sz, res.sy, res.sx};
    assign m_tuser = {res.rcls, res.pcls};
endmodule

### rtl/kst_checker.sv
// Port-level checker for the tilt sensor, bound to the top level.
`include "assert_macros.svh"
module kst_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [3:0]   m_tuser
);
    `ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `ASSERT_IMP(a_pcls, aclk, aresetn, m_tvalid, m_tuser[1:0] != 2'd3, "bad pitch class")
    `ASSERT_IMP(a_rcls, aclk, aresetn, m_tvalid, m_tuser[3:2] != 2'd3, "bad roll class")
    `ASSERT_IMP(a_known, aclk, aresetn, 1'b1, !$isunknown({s_tready, m_tvalid}), "unknown handshake")
endmodule

bind kalman_smoothed_tilt_sensor_core kst_checker u_chk (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
